@@ sv/setc_pkg.sv @@
`timescale 1ns / 1ps
package setc_pkg;

  localparam int RING_DEPTH = 256;

  localparam logic [3:0] MODE_TASK_IN  = 4'd0;
  localparam logic [3:0] MODE_TASK_OUT = 4'd1;
  localparam logic [3:0] MODE_Q_SEND   = 4'd2;
  localparam logic [3:0] MODE_Q_RECV   = 4'd3;
  localparam logic [3:0] MODE_ISR_IN   = 4'd4;
  localparam logic [3:0] MODE_ISR_OUT  = 4'd5;
  localparam logic [3:0] MODE_MARKER   = 4'd6;
  localparam logic [3:0] MODE_READ     = 4'd7;
  localparam logic [3:0] MODE_CLEAR    = 4'd8;

  localparam logic [2:0] ST_RECORDED   = 3'd0;
  localparam logic [2:0] ST_RING_FULL  = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_NO_ACTION  = 3'd3;
  localparam logic [2:0] ST_READ_OK    = 3'd4;
  localparam logic [2:0] ST_READ_EMPTY = 3'd5;

  localparam logic [13:0] QMASK = 14'h3FFF;
  localparam logic [15:0] QBASE = 16'h4000;
  localparam logic [15:0] IBASE = 16'h8000;
  localparam logic [7:0]  IPRIO = 8'hFF;

  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] timestamp_us;
    logic [31:0] handle;
    logic [15:0] event_number;
    logic [7:0]  task_priority;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] event_timestamp;
    logic [15:0] event_ident;
    logic [2:0]  event_kind;
    logic [7:0]  event_priority;
    logic [5:0]  task_number;
    logic [31:0] task_busy_us;
    logic [31:0] recorded_count;
    logic [31:0] dropped_count;
    logic [31:0] wrap_count;
    logic [8:0]  peak_fill;
    logic [8:0]  fill_level;
  } out_word_t;

  typedef struct packed {
    logic [31:0] ts;
    logic [15:0] id;
    logic [2:0]  kind;
    logic [7:0]  prio;
  } entry_t;

endpackage

@@ sv/setc_in_if.sv @@
`timescale 1ns / 1ps
interface setc_in_if;
  logic                valid;
  logic                ready;
  setc_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/setc_out_if.sv @@
`timescale 1ns / 1ps
interface setc_out_if;
  logic                valid;
  logic                ready;
  setc_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/scheduler_event_trace_capture.sv @@
`timescale 1ns / 1ps
// Scheduler event trace capture. Each input word is one event, a read of the
// oldest ring entry, or a clear; each yields exactly one result word with the
// counters after the step. Task events search the task table one slot per
// cycle with a single shared key comparator; a miss, or a hit in one of the
// last two slots, scans every slot, and an earlier hit stops the scan in the
// cycle after the match. Other event words go through the push step, and a
// read of a non-empty ring goes through the registered ring read. The result
// is held until out_ch.ready, and the block takes no new word until the
// result has been handed off. The ring has one write port and one registered
// read port, and its pointers guard every read, so it needs no clearing pass
// after reset.
module scheduler_event_trace_capture #(
  parameter int TASK_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  setc_in_if.sink     in_ch,
  setc_out_if.source  out_ch
);

  localparam int RW = $clog2(setc_pkg::RING_DEPTH);
  localparam int PW = RW + 1;
  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;  // one table slot a cycle
  localparam logic [2:0] S_TASK = 3'd2;  // update the found slot
  localparam logic [2:0] S_PUSH = 3'd3;  // ring write and counters
  localparam logic [2:0] S_READ = 3'd4;  // ring data settles
  localparam logic [2:0] S_OUT  = 3'd5;  // hold result

  logic [2:0]  state_r, state_nxt;
  logic        enable_r;
  setc_pkg::in_word_t  req_r;
  setc_pkg::out_word_t res_r;

  setc_pkg::entry_t ring_mem [setc_pkg::RING_DEPTH];
  setc_pkg::entry_t rd_data_r;

  logic [31:0] task_key   [TASK_SLOTS];
  logic [7:0]  task_prio  [TASK_SLOTS];
  logic [5:0]  task_num   [TASK_SLOTS];
  logic [31:0] task_start [TASK_SLOTS];
  logic [31:0] task_busy  [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] task_valid_r;

  logic [PW-1:0] wp_r, rp_r;
  logic [5:0]    next_num_r;
  logic [31:0]   prev_ts_r, rec_r, drop_r, wrap_r;
  logic [PW-1:0] peak_r;

  logic [CW-1:0] scan_r;
  logic          hit_r, free_ok_r;
  logic [SW-1:0] hit_idx_r, free_idx_r;

  // push payload built up before S_PUSH
  setc_pkg::entry_t push_r;

  logic [PW-1:0] fill;
  logic          mode_ev, needs_h, do_event;

  assign fill     = wp_r - rp_r;
  assign mode_ev  = in_ch.data.mode <= setc_pkg::MODE_MARKER;
  assign needs_h  = in_ch.data.mode <= setc_pkg::MODE_Q_RECV;
  assign do_event = mode_ev && enable_r && !(needs_h && in_ch.data.handle == 32'd0);

  // counters shown in the result track the live registers, which hold still
  // while the result waits
  setc_pkg::out_word_t res_out;
  always_comb begin
    res_out = res_r;
    res_out.recorded_count = rec_r;
    res_out.dropped_count  = drop_r;
    res_out.wrap_count     = wrap_r;
    res_out.peak_fill      = peak_r;
    res_out.fill_level     = fill;
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = res_out;

  // starting result for an accepted word
  setc_pkg::out_word_t res_init;
  always_comb begin
    res_init = '0;
    res_init.status = setc_pkg::ST_NO_ACTION;
    if (in_ch.data.mode == setc_pkg::MODE_READ)
      res_init.status = (fill == '0) ? setc_pkg::ST_READ_EMPTY : setc_pkg::ST_READ_OK;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) begin
        if (do_event && in_ch.data.mode <= setc_pkg::MODE_TASK_OUT) state_nxt = S_SCAN;
        else if (do_event) state_nxt = S_PUSH;
        else if (in_ch.data.mode == setc_pkg::MODE_READ && fill != '0) state_nxt = S_READ;
        else state_nxt = S_OUT;
      end
      S_SCAN: if (scan_r == CW'(TASK_SLOTS - 1) || hit_r) state_nxt = S_TASK;
      S_TASK: state_nxt = (hit_r || free_ok_r) ? S_PUSH : S_OUT;
      S_PUSH: state_nxt = S_OUT;
      S_READ: state_nxt = S_OUT;
      S_OUT:  if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) enable_r <= 1'b0;
    else if (cfg_we) enable_r <= cfg_wdata;
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == S_PUSH && fill < PW'(setc_pkg::RING_DEPTH))
      ring_mem[wp_r[RW-1:0]] <= push_r;
    rd_data_r <= ring_mem[rp_r[RW-1:0]];
  end

  // search: a single comparator walks the slots
  logic [SW-1:0] scan_idx;
  logic          key_eq;
  assign scan_idx = scan_r[SW-1:0];
  assign key_eq   = task_valid_r[scan_idx] && task_key[scan_idx] == req_r.handle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r    <= '0;
      hit_r     <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (state_r == S_IDLE) begin
      scan_r    <= '0;
      hit_r     <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (state_r == S_SCAN && !hit_r) begin
      if (key_eq) begin
        hit_r     <= 1'b1;
        hit_idx_r <= scan_idx;
      end else if (!task_valid_r[scan_idx] && !free_ok_r) begin
        free_ok_r  <= 1'b1;
        free_idx_r <= scan_idx;
      end
      if (scan_r != CW'(TASK_SLOTS - 1)) scan_r <= scan_r + CW'(1);
    end
  end

  logic [31:0] start_v, busy_v;
  logic [7:0]  prio_v;
  logic [5:0]  num_v;
  logic [SW-1:0] slot_v;
  assign slot_v  = hit_r ? hit_idx_r : free_idx_r;
  assign start_v = hit_r ? task_start[slot_v] : 32'd0;
  assign busy_v  = hit_r ? task_busy[slot_v] : 32'd0;
  assign prio_v  = hit_r ? task_prio[slot_v] : req_r.task_priority;
  assign num_v   = hit_r ? task_num[slot_v] : next_num_r;

  logic [31:0] busy_new;
  always_comb begin
    busy_new = busy_v;
    if (req_r.mode == setc_pkg::MODE_TASK_OUT && req_r.timestamp_us >= start_v)
      busy_new = busy_v + (req_r.timestamp_us - start_v);
  end

  // task table write, at S_TASK
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_valid_r <= '0;
      next_num_r   <= '0;
    end else if (state_r == S_TASK && (hit_r || free_ok_r)) begin
      if (!hit_r) begin
        task_valid_r[slot_v] <= 1'b1;
        next_num_r           <= next_num_r + 6'd1;
      end
      task_key[slot_v]   <= req_r.handle;
      task_prio[slot_v]  <= prio_v;
      task_num[slot_v]   <= num_v;
      task_start[slot_v] <= (req_r.mode == setc_pkg::MODE_TASK_IN) ?
                            req_r.timestamp_us : start_v;
      task_busy[slot_v]  <= busy_new;
    end
  end

  // main datapath: counters, pointers, result
  logic [PW-1:0] fill_after;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; prev_ts_r <= '0;
      rec_r <= '0; drop_r <= '0; wrap_r <= '0; peak_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_ch.valid) begin
          req_r <= in_ch.data;
          res_r <= res_init;
          push_r.ts <= in_ch.data.timestamp_us;
          push_r.kind <= in_ch.data.mode[2:0];
          if (in_ch.data.mode == setc_pkg::MODE_Q_SEND ||
              in_ch.data.mode == setc_pkg::MODE_Q_RECV) begin
            push_r.id   <= {2'b00, in_ch.data.handle[15:2] & setc_pkg::QMASK} |
                           setc_pkg::QBASE;
            push_r.prio <= 8'd0;
          end else if (in_ch.data.mode == setc_pkg::MODE_ISR_IN ||
                       in_ch.data.mode == setc_pkg::MODE_ISR_OUT) begin
            push_r.id   <= in_ch.data.event_number | setc_pkg::IBASE;
            push_r.prio <= setc_pkg::IPRIO;
          end else begin
            push_r.id   <= in_ch.data.event_number;
            push_r.prio <= 8'd0;
          end
          if (in_ch.data.mode == setc_pkg::MODE_CLEAR) begin
            wp_r <= '0; rp_r <= '0; prev_ts_r <= '0;
            rec_r <= '0; drop_r <= '0; wrap_r <= '0; peak_r <= '0;
          end
        end
        S_TASK: begin
          if (hit_r || free_ok_r) begin
            push_r.id   <= {10'd0, num_v};
            push_r.prio <= prio_v;
            res_r.task_number  <= num_v;
            res_r.task_busy_us <= busy_new;
          end else begin
            drop_r <= drop_r + 32'd1;
            res_r.status <= setc_pkg::ST_TABLE_FULL;
          end
        end
        S_PUSH: begin
          if (push_r.ts < prev_ts_r) wrap_r <= wrap_r + 32'd1;
          prev_ts_r <= push_r.ts;
          if (fill >= PW'(setc_pkg::RING_DEPTH)) begin
            drop_r <= drop_r + 32'd1;
            res_r.status <= setc_pkg::ST_RING_FULL;
          end else begin
            wp_r  <= wp_r + PW'(1);
            rec_r <= rec_r + 32'd1;
            if (fill_after > peak_r) peak_r <= fill_after;
            res_r.status <= setc_pkg::ST_RECORDED;
          end
        end
        S_READ: begin
          res_r.event_timestamp <= rd_data_r.ts;
          res_r.event_ident     <= rd_data_r.id;
          res_r.event_kind      <= rd_data_r.kind;
          res_r.event_priority  <= rd_data_r.prio;
          rp_r <= rp_r + PW'(1);
        end
        default: ;
      endcase
    end
  end

  assign fill_after = fill + PW'(1);

endmodule
